### sv/dcf77_time_code_receiver_macros.svh
// Assertion macros for the DCF77 time code receiver.
// Used by the top level; bodies are empty when SYNTHESIS is defined.
`ifndef DCF77_TIME_CODE_RECEIVER_MACROS_SVH
`define DCF77_TIME_CODE_RECEIVER_MACROS_SVH
`ifndef SYNTHESIS
`define DCF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dcf77 receiver check failed");
`define DCF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dcf77 receiver check failed");
`else
`define DCF_ASSERT_NOW(label, clk, rstn, ante, cons)
`define DCF_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### sv/dcf_pkg.sv
// Shared types, constants and BCD helper for the DCF77 time code receiver.
// No dependencies; imported by every module of the block.
package dcf_pkg;

    localparam int MEAN_DEPTH    = 8;
    localparam int TELEGRAM_BITS = 60;

    localparam int CNT_W      = 16;
    localparam int SLOT_W     = $clog2(MEAN_DEPTH);
    localparam int HIST_SUM_W = CNT_W + $clog2(MEAN_DEPTH);
    localparam int TPOS_W     = $clog2(TELEGRAM_BITS);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // configuration register indexes
    localparam logic [1:0] CFG_INVERT    = 2'd0;
    localparam logic [1:0] CFG_MIN_COUNT = 2'd1;
    localparam logic [1:0] CFG_MEAN_SEED = 2'd2;

    localparam logic [CNT_W-1:0] MIN_COUNT_RST = 16'd100;
    localparam logic [CNT_W-1:0] MEAN_SEED_RST = 16'd500;

    // telegram positions
    localparam int TB_Z1    = 17;
    localparam int TB_Z2    = 18;
    localparam int TB_START = 20;

    localparam logic [7:0] BCD_WEIGHT [8] = '{8'd1, 8'd2, 8'd4, 8'd8,
                                              8'd10, 8'd20, 8'd40, 8'd80};

    typedef struct packed {
        logic sample_en;
        logic tick_en;
        logic level;
    } dcf_step_t;

    typedef struct packed {
        logic data_sec;
        logic bit_val;
    } dcf_class_t;

    typedef struct packed {
        logic [6:0] minute;
        logic [5:0] hour;
        logic [5:0] day;
        logic [2:0] wday;
        logic [4:0] month;
        logic [7:0] year;
    } dcf_time_t;

    // weighted BCD value of up to eight bits, unused upper bits zero
    function automatic logic [7:0] bcd_value(logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc + BCD_WEIGHT[i];
        end
        return acc;
    endfunction

endpackage

### sv/dcf_pulse_class.sv
// Carrier sample counter, pulse history ring and per-second bit classifier.
// Depends on dcf_pkg.
module dcf_pulse_class
    import dcf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  dcf_step_t        step,
    input  logic             cfg_invert,
    input  logic [CNT_W-1:0] cfg_min_count,
    input  logic [CNT_W-1:0] cfg_mean_seed,
    output dcf_class_t       cls
);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      hist_reg [MEAN_DEPTH];
    logic [HIST_SUM_W-1:0] sum_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  seeded_reg;

    logic [CNT_W-1:0]      old_entry;
    logic [HIST_SUM_W-1:0] base_sum;
    logic [HIST_SUM_W-1:0] sum_next;
    logic [CNT_W-1:0]      average;
    logic [SLOT_W-1:0]     slot_next;

    // before seeding every entry reads as the seed
    always_comb begin
        old_entry = seeded_reg ? hist_reg[slot_reg] : cfg_mean_seed;
        base_sum  = seeded_reg ? sum_reg
                  : HIST_SUM_W'(cfg_mean_seed) * HIST_SUM_W'(MEAN_DEPTH);
        sum_next  = base_sum - HIST_SUM_W'(old_entry) + HIST_SUM_W'(count_reg);
        average   = CNT_W'(sum_next / MEAN_DEPTH);
        slot_next = (slot_reg == SLOT_W'(MEAN_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
        cls.data_sec = (count_reg >= cfg_min_count);
        cls.bit_val  = cls.data_sec && (count_reg > average);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            sum_reg    <= '0;
            slot_reg   <= '0;
            seeded_reg <= 1'b0;
        end else if (step.sample_en) begin
            if ((step.level ^ cfg_invert) && count_reg != CNT_MAX)
                count_reg <= count_reg + 1'b1;
        end else if (step.tick_en) begin
            count_reg  <= '0;
            seeded_reg <= 1'b1;
            if (cls.data_sec) begin
                sum_reg  <= sum_next;
                slot_reg <= slot_next;
            end else begin
                sum_reg  <= base_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step.tick_en) begin
            for (int i = 0; i < MEAN_DEPTH; i++) begin
                if (cls.data_sec && slot_reg == SLOT_W'(i))
                    hist_reg[i] <= count_reg;
                else if (!seeded_reg)
                    hist_reg[i] <= cfg_mean_seed;
            end
        end
    end

endmodule

### sv/dcf_tgm_decode.sv
// Telegram bit store, minute decode with parity checks and held time.
// Depends on dcf_pkg.
module dcf_tgm_decode
    import dcf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              tick_en,
    input  dcf_class_t        cls,
    output logic [TPOS_W-1:0] bit_index,
    output logic              time_valid,
    output dcf_time_t         time_out
);

    logic [TELEGRAM_BITS-1:0] bits_reg;
    logic [TPOS_W-1:0]        pos_reg;
    dcf_time_t                held_reg;

    dcf_time_t   fresh;
    logic        checks_ok;
    logic        p1_ok, p2_ok, p3_ok;
    logic [TPOS_W-1:0] pos_next;

    always_comb begin
        fresh.minute = 7'(bcd_value({1'b0, bits_reg[27:21]}));
        fresh.hour   = 6'(bcd_value({2'b0, bits_reg[34:29]}));
        fresh.day    = 6'(bcd_value({2'b0, bits_reg[41:36]}));
        fresh.wday   = 3'(bcd_value({5'b0, bits_reg[44:42]}));
        fresh.month  = 5'(bcd_value({3'b0, bits_reg[49:45]}));
        fresh.year   = bcd_value(bits_reg[57:50]);
        // even parity over data bits plus the parity bit
        p1_ok = !(^bits_reg[28:21]);
        p2_ok = !(^bits_reg[35:29]);
        p3_ok = !(^bits_reg[58:36]);
        checks_ok = bits_reg[TB_START] && (bits_reg[TB_Z1] != bits_reg[TB_Z2])
                  && p1_ok && p2_ok && p3_ok;
        pos_next = (pos_reg == TPOS_W'(TELEGRAM_BITS - 1)) ? '0 : pos_reg + 1'b1;

        if (cls.data_sec) begin
            bit_index  = pos_reg;
            time_valid = 1'b0;
            time_out   = held_reg;
        end else begin
            bit_index  = '0;
            time_valid = checks_ok;
            time_out   = checks_ok ? fresh : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg <= '0;
            pos_reg  <= '0;
            held_reg <= '0;
        end else if (tick_en) begin
            if (cls.data_sec) begin
                bits_reg[pos_reg] <= cls.bit_val;
                pos_reg           <= pos_next;
            end else begin
                bits_reg <= '0;
                pos_reg  <= '0;
                held_reg <= time_out;
            end
        end
    end

endmodule

### sv/dcf77_time_code_receiver.sv
// Top level of the DCF77 time code receiver: input register, config registers,
// result register. Depends on dcf_pkg, dcf_pulse_class, dcf_tgm_decode, macros.
//
//  channel | direction | word                                   | handshake
//  s_      | in        | tuser operation, tdata[0] signal_level | s_tvalid/s_tready
//  m_      | out       | tuser gap_decoded, tdata time fields   | m_tvalid/m_tready
//  cfg_    | in        | cfg_index, cfg_data                    | cfg_valid/cfg_ready
//
// Each word is held in the input register while its step is worked out;
// a tick's result is registered into the output register as the tick advances.
// One word per cycle is taken; only a tick waiting on an unread result stalls.
// Reset (aresetn low, synchronous) clears counters, history state and telegram.
// Configuration writes are always taken (cfg_ready held high).
`include "dcf77_time_code_receiver_macros.svh"
module dcf77_time_code_receiver
    import dcf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] signal_level, [7:1] zero
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // time_valid, bit_value, bit_index[5:0],
                                   // minute[6:0], hour[5:0], day[5:0],
                                   // weekday[2:0], month[4:0], year[7:0], zero pad
    output logic        m_tuser,   // [0] gap_decoded
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic             in_valid_reg;
    logic             in_op_reg;
    logic             in_level_reg;
    logic             cfg_invert_reg;
    logic [CNT_W-1:0] cfg_min_reg;
    logic [CNT_W-1:0] cfg_seed_reg;
    logic             out_valid_reg;
    logic             out_gap_reg;
    logic [42:0]      out_data_reg;

    logic              advance;
    dcf_step_t         step;
    dcf_class_t        cls;
    logic [TPOS_W-1:0] bit_index;
    logic              time_valid;
    dcf_time_t         time_out;

    assign advance  = in_valid_reg && (!in_op_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign step.sample_en = advance && !in_op_reg;
    assign step.tick_en   = advance && in_op_reg;
    assign step.level     = in_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg    <= s_tuser;
            in_level_reg <= s_tdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_invert_reg <= 1'b0;
            cfg_min_reg    <= MIN_COUNT_RST;
            cfg_seed_reg   <= MEAN_SEED_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_INVERT:    cfg_invert_reg <= cfg_data[0];
                CFG_MIN_COUNT: cfg_min_reg    <= cfg_data;
                CFG_MEAN_SEED: cfg_seed_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    dcf_pulse_class u_class (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .cfg_invert    (cfg_invert_reg),
        .cfg_min_count (cfg_min_reg),
        .cfg_mean_seed (cfg_seed_reg),
        .cls           (cls)
    );

    dcf_tgm_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_en    (step.tick_en),
        .cls        (cls),
        .bit_index  (bit_index),
        .time_valid (time_valid),
        .time_out   (time_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step.tick_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step.tick_en) begin
            out_gap_reg  <= !cls.data_sec;
            out_data_reg <= {time_out.year, time_out.month, time_out.wday,
                             time_out.day, time_out.hour, time_out.minute,
                             bit_index, cls.bit_val, time_valid};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_gap_reg;
    assign m_tdata  = {5'b0, out_data_reg};

    `DCF_ASSERT_NOW(a_gap_no_bit, aclk, aresetn, m_tvalid && m_tuser,
                    m_tdata[7:1] == 7'd0)
    `DCF_ASSERT_NOW(a_data_not_valid, aclk, aresetn, m_tvalid && !m_tuser,
                    !m_tdata[0])
    `DCF_ASSERT_NOW(a_bad_time_zero, aclk, aresetn, m_tvalid && m_tuser && !m_tdata[0],
                    m_tdata[42:8] == 35'd0)
    `DCF_ASSERT_NOW(a_stall_only_tick, aclk, aresetn, !s_tready,
                    in_valid_reg && in_op_reg && out_valid_reg)
    `DCF_ASSERT_NEXT(a_sample_no_result, aclk, aresetn,
                     step.sample_en && !out_valid_reg, !m_tvalid)

endmodule

### sim/dcf77_time_code_receiver_test.sv
// Self-checking bench for the DCF77 time code receiver: sample and second words
// with random gaps on both sides, every result checked against a local model.
// Depends on dcf_pkg and the dcf77_time_code_receiver RTL.
module dcf77_time_code_receiver_test;
    import dcf_pkg::*;

    localparam logic [1:0] CFG_SPARE    = 2'd3;  // unmapped register index
    localparam logic       OP_SAMPLE    = 1'b0;
    localparam logic       OP_TICK      = 1'b1;
    localparam int         QUIET_LIMIT  = 1000;
    localparam int         RANDOM_WORDS = 1700;

    typedef struct {
        logic       gap;
        logic       time_ok;
        logic       bit_val;
        logic [5:0] index;
        dcf_time_t  tm;
    } dcf_report_t;

    class dcf_time_scoreboard;
        logic        invert;
        logic [15:0] min_count;
        logic [15:0] seed;
        logic [15:0] pulse_count;
        logic [15:0] ring [MEAN_DEPTH];
        logic [19:0] ring_total;
        int unsigned ring_ptr;
        logic        ring_loaded;
        logic [63:0] frame;
        int unsigned frame_ptr;
        dcf_time_t   held;
        dcf_report_t reports_due [$];
        int          mismatches;
        int          samples, seconds, gaps, good_frames;

        function new();
            invert      = 1'b0;
            min_count   = MIN_COUNT_RST;
            seed        = MEAN_SEED_RST;
            pulse_count = '0;
            foreach (ring[i]) ring[i] = '0;
            ring_total  = '0;
            ring_ptr    = 0;
            ring_loaded = 1'b0;
            frame       = '0;
            frame_ptr   = 0;
            held        = '0;
            mismatches  = 0;
            samples     = 0;
            seconds     = 0;
            gaps        = 0;
            good_frames = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_INVERT:    invert = data[0];
                CFG_MIN_COUNT: min_count = data;
                CFG_MEAN_SEED: seed = data;
                default: ;
            endcase
        endfunction

        // bit that a data second with this count would get in the current ring
        function logic marks_one(int unsigned count);
            int unsigned total, oldest;
            total  = ring_loaded ? 32'(ring_total) : 32'(seed) * MEAN_DEPTH;
            oldest = ring_loaded ? 32'(ring[ring_ptr]) : 32'(seed);
            return count > (total - oldest + count) / MEAN_DEPTH;
        endfunction

        function int unsigned bcd_sum(int unsigned first, int unsigned n,
                                      inout int unsigned ones);
            int unsigned acc;
            acc = 0;
            for (int i = 0; i < n; i++) begin
                if (frame[first + i]) begin
                    acc += 32'(BCD_WEIGHT[i]);
                    ones++;
                end
            end
            return acc;
        endfunction

        function logic decode_frame();
            logic        ok;
            int unsigned ones;
            dcf_time_t   t;
            ok = frame[TB_START] && (frame[TB_Z1] != frame[TB_Z2]);
            ones = 0;
            t.minute = 7'(bcd_sum(21, 7, ones));
            if (ones[0] ^ frame[28]) ok = 1'b0;
            ones = 0;
            t.hour = 6'(bcd_sum(29, 6, ones));
            if (ones[0] ^ frame[35]) ok = 1'b0;
            ones = 0;
            t.day   = 6'(bcd_sum(36, 6, ones));
            t.wday  = 3'(bcd_sum(42, 3, ones));
            t.month = 5'(bcd_sum(45, 5, ones));
            t.year  = 8'(bcd_sum(50, 8, ones));
            if (ones[0] ^ frame[58]) ok = 1'b0;
            held = ok ? t : '0;
            return ok;
        endfunction

        function void note_word(logic op, logic level);
            dcf_report_t r;
            if (op == OP_SAMPLE) begin
                samples++;
                if ((level ^ invert) && pulse_count != 16'hFFFF) pulse_count++;
                return;
            end
            seconds++;
            if (!ring_loaded) begin
                foreach (ring[i]) ring[i] = seed;
                ring_total  = 20'(32'(seed) * MEAN_DEPTH);
                ring_loaded = 1'b1;
            end
            r.gap     = 1'b0;
            r.time_ok = 1'b0;
            r.bit_val = 1'b0;
            r.index   = '0;
            if (pulse_count >= min_count) begin
                r.bit_val       = marks_one(32'(pulse_count));
                ring_total      = ring_total - 20'(ring[ring_ptr]) + 20'(pulse_count);
                ring[ring_ptr]  = pulse_count;
                ring_ptr        = (ring_ptr + 1) % MEAN_DEPTH;
                r.index         = 6'(frame_ptr);
                frame[frame_ptr] = r.bit_val;
                frame_ptr       = (frame_ptr + 1) % TELEGRAM_BITS;
            end else begin
                gaps++;
                r.gap     = 1'b1;
                r.time_ok = decode_frame();
                if (r.time_ok) good_frames++;
                frame     = '0;
                frame_ptr = 0;
            end
            pulse_count = '0;
            r.tm = held;
            reports_due.push_back(r);
        endfunction

        function void match_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%s mismatch at %0t: expected %0d, got %0d",
                             name, $time, want, got);
            end
        endfunction

        function void check_word(dcf_report_t got);
            dcf_report_t want;
            if (reports_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word at %0t with nothing expected", $time);
                return;
            end
            want = reports_due.pop_front();
            match_field("gap_decoded",   want.gap,      got.gap);
            match_field("time_valid",    want.time_ok,  got.time_ok);
            match_field("bit_value",     want.bit_val,  got.bit_val);
            match_field("bit_index",     want.index,    got.index);
            match_field("minute_value",  want.tm.minute, got.tm.minute);
            match_field("hour_value",    want.tm.hour,  got.tm.hour);
            match_field("day_of_month",  want.tm.day,   got.tm.day);
            match_field("weekday_value", want.tm.wday,  got.tm.wday);
            match_field("month_value",   want.tm.month, got.tm.month);
            match_field("year_value",    want.tm.year,  got.tm.year);
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    logic smooth = 1'b0;  // no idling for the current stretch
    logic steady = 1'b0;  // no idling for the rest of the run
    int   hold_left    = 0;
    int   sent_words   = 0;
    int   quiet_cycles = 0;

    dcf_time_scoreboard sb;

    dcf77_time_code_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin : watch_ports
        dcf_report_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_word(s_tuser, s_tdata[0]);
            if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
            if (m_tvalid && m_tready) begin
                got.gap       = m_tuser;
                got.time_ok   = m_tdata[0];
                got.bit_val   = m_tdata[1];
                got.index     = m_tdata[7:2];
                got.tm.minute = m_tdata[14:8];
                got.tm.hour   = m_tdata[20:15];
                got.tm.day    = m_tdata[26:21];
                got.tm.wday   = m_tdata[29:27];
                got.tm.month  = m_tdata[34:30];
                got.tm.year   = m_tdata[42:35];
                sb.check_word(got);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no handshake for %0d cycles", QUIET_LIMIT);
            $display("FAIL dcf77_time_code_receiver");
            $finish;
        end
    end

    // result side back-pressure in bursts
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else if (!steady && !smooth && $urandom_range(0, 7) == 0) begin
            m_tready  = 1'b0;
            hold_left = $urandom_range(0, 4);
        end else begin
            m_tready = 1'b1;
        end
    end

    task automatic send_word(logic op, logic level);
        if (!steady && !smooth && $urandom_range(0, 9) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {7'd0, level};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent_words++;
    endtask

    task automatic write_register(logic [1:0] idx, logic [15:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.reports_due.size() != 0) @(negedge aclk);
    endtask

    // samples still in the pipe can change the count, so wait them out too
    task automatic settle();
        drain();
        repeat (6) @(negedge aclk);
    endtask

    // hi carrier samples and lo quiet samples in random order, then the tick
    task automatic send_second(int hi, int lo);
        logic on;
        on = ~sb.invert;
        while (hi + lo > 0) begin
            if ($urandom_range(1, hi + lo) <= hi) begin
                send_word(OP_SAMPLE, on);
                hi--;
            end else begin
                send_word(OP_SAMPLE, ~on);
                lo--;
            end
        end
        send_word(OP_TICK, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_gap();
        send_second(sb.min_count == 0 ? 0 : $urandom_range(0, sb.min_count - 1),
                    $urandom_range(0, 2));
    endtask

    // pick a count that lands on the wanted side of the running mean
    task automatic send_data_bit(logic b);
        int count;
        count = int'(sb.min_count);
        if (b) begin
            count += $urandom_range(1, 3);
            while (!sb.marks_one(count) && count < sb.min_count + 64) count++;
        end
        send_second(count, $urandom_range(0, 1));
    endtask

    task automatic send_minute();
        logic [59:0] f;
        int          n, v;
        f = 60'({$urandom, $urandom});
        if ($urandom_range(0, 3) != 0) begin
            v = $urandom_range(0, 59);
            f[27:21] = {3'(v / 10), 4'(v % 10)};
            v = $urandom_range(0, 23);
            f[34:29] = {2'(v / 10), 4'(v % 10)};
            v = $urandom_range(1, 31);
            f[41:36] = {2'(v / 10), 4'(v % 10)};
            f[44:42] = 3'($urandom_range(1, 7));
            v = $urandom_range(1, 12);
            f[49:45] = {1'(v / 10), 4'(v % 10)};
            v = $urandom_range(0, 99);
            f[57:50] = {4'(v / 10), 4'(v % 10)};
        end
        f[TB_Z1]    = 1'($urandom_range(0, 1));
        f[TB_Z2]    = ~f[TB_Z1];
        f[TB_START] = 1'b1;
        f[28] = ^f[27:21];
        f[35] = ^f[34:29];
        f[58] = ^f[57:36];
        // corrupt one bit now and then
        if ($urandom_range(0, 3) == 0) begin
            v = $urandom_range(TB_Z1, 58);
            f[v] = ~f[v];
        end
        // a leap second carries a sixtieth bit
        n = ($urandom_range(0, 4) == 0) ? TELEGRAM_BITS : TELEGRAM_BITS - 1;
        send_gap();
        for (int i = 0; i < n; i++) send_data_bit(f[i]);
        send_gap();
    endtask

    task automatic send_run(int n);
        repeat (n) send_data_bit(1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1)) send_gap();
    endtask

    task automatic send_noise();
        repeat ($urandom_range(10, 40))
            send_word($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
    endtask

    task automatic mix_until(int limit);
        while (sent_words < limit) begin
            smooth = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9)) inside
                [0:5]: send_minute();
                [6:7]: send_run($urandom_range(1, 75));
                8: send_noise();
                default: begin
                    drain();
                    send_minute();
                end
            endcase
        end
        smooth = 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // seed is taken at the first tick, so write it before any tick
        write_register(CFG_SPARE, 16'($urandom));
        write_register(CFG_INVERT, 16'hFFFF);
        write_register(CFG_MIN_COUNT, 16'd0);
        write_register(CFG_MEAN_SEED, 16'd3);
        send_word(OP_SAMPLE, 1'b0);
        send_word(OP_SAMPLE, 1'b1);
        send_word(OP_SAMPLE, 1'b0);
        send_word(OP_TICK, 1'b0);
        send_word(OP_TICK, 1'b1);
        repeat (4) send_word(OP_SAMPLE, 1'b0);
        send_word(OP_TICK, 1'b0);
        settle();
        write_register(CFG_INVERT, 16'd0);
        write_register(CFG_MIN_COUNT, 16'hFFFF);
        repeat (3) send_word(OP_SAMPLE, 1'b1);
        send_word(OP_SAMPLE, 1'b0);
        send_word(OP_TICK, 1'b1);
        send_word(OP_TICK, 1'b0);

        settle();
        write_register(CFG_MIN_COUNT, 16'd1);
        write_register(CFG_MEAN_SEED, 16'hFFFF);
        write_register(CFG_INVERT, 16'd1);
        sent_words = 0;
        // refill the ring with small counts
        repeat (10) send_data_bit(1'b0);
        send_run(63);
        mix_until(900);

        settle();
        write_register(CFG_INVERT, 16'd0);
        write_register(CFG_MIN_COUNT, 16'd2);
        write_register(CFG_MEAN_SEED, 16'd0);
        mix_until(1400);

        settle();
        write_register(CFG_MIN_COUNT, 16'd1);
        write_register(CFG_INVERT, 16'd1);
        steady = 1'b1;
        mix_until(RANDOM_WORDS);

        settle();
        $display("covered %0d samples, %0d seconds, %0d minute marks, %0d good telegrams",
                 sb.samples, sb.seconds, sb.gaps, sb.good_frames);
        $display("%0d mismatching fields or stray results", sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASS dcf77_time_code_receiver");
        else
            $display("FAIL dcf77_time_code_receiver");
        $finish;
    end

endmodule
